>>> hw/rtl/swrm_pkg.sv
// ----------------------------------------------------------------------------
// swrm_pkg
// Shared constants, types and codes of the sliding-window rate meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swrm_pkg;

   // channels and rings
   localparam int CHANNELS   = 2;
   localparam int RING_DEPTH = 64;
   localparam int CH_W       = $clog2(CHANNELS);
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);
   localparam int MEM_DEPTH  = CHANNELS * RING_DEPTH;
   localparam int ADDR_W     = CH_W + PTR_W;

   // field widths
   localparam int TIME_W   = 32;
   localparam int AMOUNT_W = 20;
   localparam int SUM_W    = 32;
   localparam int RATE_W   = 32;
   localparam int WIN_W    = 20;
   localparam int MAXE_W   = 7;
   localparam int ENTRY_W  = TIME_W + AMOUNT_W;

   // stream widths
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;

   // rate arithmetic
   localparam int SCALE_W    = 10;
   localparam int NUM_W      = SUM_W + SCALE_W;
   localparam int DEN_W      = TIME_W;
   localparam int STEP_W     = $clog2(NUM_W);
   localparam int RATE_SCALE = 1000;
   localparam int MIN_AGE_MS = 1000;

   // configuration registers
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_MS   = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_ENTRIES = 1'd1;
   localparam logic [WIN_W-1:0]      WINDOW_MS_RESET   = WIN_W'(10000);
   localparam logic [MAXE_W-1:0]     MAX_ENTRIES_RESET = MAXE_W'(64);

   // operation codes
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_CHECK,
      ST_REC_WRITE,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FINISH
   } swrm_state_type;

   typedef struct packed {
      logic latch_item;
      logic rd_head;
      logic drop;
      logic rec_write;
      logic mul_load;
      logic div_start;
      logic out_load;
   } swrm_cmd_type;

   typedef struct packed {
      logic op_query;
      logic ring_full;
      logic ring_empty;
      logic last_entry;
      logic evict;
      logic div_done;
      logic out_busy;
   } swrm_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/swrm_div.sv
// ----------------------------------------------------------------------------
// swrm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrm_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [swrm_pkg::NUM_W-1:0]     numerator,
   input  wire logic [swrm_pkg::DEN_W-1:0]     divisor,
   output logic                                done,
   output logic [swrm_pkg::NUM_W-1:0]          quotient
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [swrm_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [swrm_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [swrm_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [swrm_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [swrm_pkg::DEN_W:0]       trial;
   logic                           q_bit;

   assign trial = {rem_ff, num_ff[swrm_pkg::NUM_W-1]};
   assign q_bit = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = swrm_pkg::STEP_W'(swrm_pkg::NUM_W - 1);
         num_in  = numerator;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // quotient bits shift in where numerator bits leave
         num_in = {num_ff[swrm_pkg::NUM_W-2:0], q_bit};
         rem_in = q_bit ? swrm_pkg::DEN_W'(trial - {1'b0, den_ff})
                        : trial[swrm_pkg::DEN_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

`default_nettype wire

>>> hw/rtl/swrm_ctrl.sv
// ----------------------------------------------------------------------------
// swrm_ctrl
// Sequencer for record and query items of the rate meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrm_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire swrm_pkg::swrm_status_type status,
   output swrm_pkg::swrm_cmd_type        cmd
);

   swrm_pkg::swrm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swrm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         swrm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_item = 1'b1;
               state_in       = swrm_pkg::ST_DECODE;
            end
         end
         swrm_pkg::ST_DECODE: begin
            if (status.op_query) begin
               state_in = status.ring_empty ? swrm_pkg::ST_FINISH : swrm_pkg::ST_READ;
            end else begin
               state_in = status.ring_full ? swrm_pkg::ST_READ : swrm_pkg::ST_REC_WRITE;
            end
         end
         swrm_pkg::ST_READ: begin
            cmd.rd_head = 1'b1;
            state_in    = swrm_pkg::ST_CHECK;
         end
         swrm_pkg::ST_CHECK: begin
            if (!status.op_query) begin
               // full ring: the oldest entry makes room
               cmd.drop = 1'b1;
               state_in = swrm_pkg::ST_REC_WRITE;
            end else if (status.evict) begin
               cmd.drop = 1'b1;
               state_in = status.last_entry ? swrm_pkg::ST_FINISH : swrm_pkg::ST_READ;
            end else begin
               state_in = swrm_pkg::ST_MUL;
            end
         end
         swrm_pkg::ST_REC_WRITE: begin
            cmd.rec_write = 1'b1;
            state_in      = swrm_pkg::ST_IDLE;
         end
         swrm_pkg::ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = swrm_pkg::ST_DIV_GO;
         end
         swrm_pkg::ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = swrm_pkg::ST_DIV_WAIT;
         end
         swrm_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = swrm_pkg::ST_FINISH;
            end
         end
         swrm_pkg::ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = swrm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swrm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/swrm_dp.sv
// ----------------------------------------------------------------------------
// swrm_dp
// Entry store, per-channel ring state, rate arithmetic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrm_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [swrm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [swrm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic [swrm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic [swrm_pkg::REQ_USER_W-1:0]     req_tuser,
   input  wire swrm_pkg::swrm_cmd_type              cmd,
   output swrm_pkg::swrm_status_type                status,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [swrm_pkg::RSP_DATA_W-1:0]          rsp_tdata
);

   // configuration
   logic [swrm_pkg::WIN_W-1:0]   window_ff;
   logic [swrm_pkg::MAXE_W-1:0]  max_ff;

   // latched item
   logic                          op_ff;
   logic [swrm_pkg::CH_W-1:0]     ch_ff;
   logic [swrm_pkg::TIME_W-1:0]   now_ff;
   logic [swrm_pkg::AMOUNT_W-1:0] amt_ff;

   // per-channel ring state
   logic [swrm_pkg::PTR_W-1:0] head_ff  [swrm_pkg::CHANNELS];
   logic [swrm_pkg::CNT_W-1:0] count_ff [swrm_pkg::CHANNELS];
   logic [swrm_pkg::SUM_W-1:0] sum_ff   [swrm_pkg::CHANNELS];

   // entry store, {amount, time}
   logic [swrm_pkg::ENTRY_W-1:0]  mem [swrm_pkg::MEM_DEPTH];
   logic [swrm_pkg::ENTRY_W-1:0]  rd_data_ff;
   logic [swrm_pkg::TIME_W-1:0]   rd_time;
   logic [swrm_pkg::AMOUNT_W-1:0] rd_amount;

   // arithmetic
   logic [swrm_pkg::NUM_W-1:0]  product_ff;
   logic [swrm_pkg::DEN_W-1:0]  divisor_ff;
   logic                        div_done;
   logic [swrm_pkg::NUM_W-1:0]  quotient;

   // result register
   logic                         rsp_valid_ff;
   logic [swrm_pkg::RATE_W-1:0]  rate_ff;
   logic [swrm_pkg::CNT_W-1:0]   entries_ff;

   logic [swrm_pkg::PTR_W-1:0]   cur_head;
   logic [swrm_pkg::CNT_W-1:0]   cur_count;
   logic [swrm_pkg::SUM_W-1:0]   cur_sum;
   logic [swrm_pkg::TIME_W-1:0]  age;
   logic [swrm_pkg::PTR_W-1:0]   wr_slot;
   logic [swrm_pkg::RATE_W-1:0]  rate_sat;

   assign cur_head  = head_ff[ch_ff];
   assign cur_count = count_ff[ch_ff];
   assign cur_sum   = sum_ff[ch_ff];
   assign rd_time   = rd_data_ff[swrm_pkg::TIME_W-1:0];
   assign rd_amount = rd_data_ff[swrm_pkg::ENTRY_W-1:swrm_pkg::TIME_W];
   assign age       = now_ff - rd_time;
   assign wr_slot   = cur_head + cur_count[swrm_pkg::PTR_W-1:0];
   assign rate_sat  = (quotient[swrm_pkg::NUM_W-1:swrm_pkg::RATE_W] != '0)
                      ? '1 : quotient[swrm_pkg::RATE_W-1:0];

   assign status.op_query   = (op_ff == swrm_pkg::OP_QUERY);
   assign status.ring_full  = (cur_count >= swrm_pkg::CNT_W'(swrm_pkg::RING_DEPTH));
   assign status.ring_empty = (cur_count == '0);
   assign status.last_entry = (cur_count == swrm_pkg::CNT_W'(1));
   assign status.evict      = (age > swrm_pkg::TIME_W'(window_ff))
                              || (cur_count > max_ff);
   assign status.div_done   = div_done;
   assign status.out_busy   = rsp_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= swrm_pkg::WINDOW_MS_RESET;
         max_ff    <= swrm_pkg::MAX_ENTRIES_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            swrm_pkg::CSR_WINDOW_MS:   window_ff <= csr_wdata[swrm_pkg::WIN_W-1:0];
            swrm_pkg::CSR_MAX_ENTRIES: max_ff    <= csr_wdata[swrm_pkg::MAXE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         op_ff  <= req_tuser[0];
         ch_ff  <= req_tuser[swrm_pkg::CH_W:1];
         now_ff <= req_tdata[swrm_pkg::TIME_W-1:0];
         amt_ff <= req_tdata[swrm_pkg::TIME_W +: swrm_pkg::AMOUNT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < swrm_pkg::CHANNELS; c++) begin
            head_ff[c]  <= '0;
            count_ff[c] <= '0;
            sum_ff[c]   <= '0;
         end
      end else if (cmd.drop) begin
         head_ff[ch_ff]  <= cur_head + 1'b1;
         count_ff[ch_ff] <= cur_count - 1'b1;
         sum_ff[ch_ff]   <= cur_sum - swrm_pkg::SUM_W'(rd_amount);
      end else if (cmd.rec_write) begin
         count_ff[ch_ff] <= cur_count + 1'b1;
         sum_ff[ch_ff]   <= cur_sum + swrm_pkg::SUM_W'(amt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rec_write) begin
         mem[{ch_ff, wr_slot}] <= {amt_ff, now_ff};
      end
      if (cmd.rd_head) begin
         rd_data_ff <= mem[{ch_ff, cur_head}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         product_ff <= swrm_pkg::NUM_W'(cur_sum) * swrm_pkg::NUM_W'(swrm_pkg::RATE_SCALE);
         // ages under one second count as one second
         divisor_ff <= (age < swrm_pkg::DEN_W'(swrm_pkg::MIN_AGE_MS))
                       ? swrm_pkg::DEN_W'(swrm_pkg::MIN_AGE_MS) : age;
      end
   end

   swrm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .numerator (product_ff),
      .divisor   (divisor_ff),
      .done      (div_done),
      .quotient  (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rate_ff    <= (cur_count == '0) ? '0 : rate_sat;
         entries_ff <= cur_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, entries_ff, rate_ff};

endmodule

`default_nettype wire

>>> hw/rtl/sliding_window_rate_meter.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_meter
// Per-channel traffic rate over a sliding time window of recorded amounts.
// ----------------------------------------------------------------------------
// channel   direction  handshake            contents
// req_      in         tvalid/tready        record or query item
// rsp_      out        tvalid/tready        rate and entries left, one per query
// csr_      in         we (no wait)         window_ms, max_entries
//
// a record writes its entry after decode, first reading back and dropping the
// oldest entry when the ring is full; a query reads and checks each entry from
// the oldest, drops the evicted ones, then scales the sum and runs the
// one-bit-per-cycle divider (42 steps); a query that leaves no entries reports zero.
// one item is in work at a time; a finished result waits in the output
// register and the next item is taken meanwhile; a query stalls at its end
// while the output register is still full and not being taken.
// reset is synchronous and empties every ring; the entry store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_rate_meter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // time_ms [31:0], amount [51:32], zero [55:52]
   input  wire logic [swrm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation [0], channel [1]
   input  wire logic [swrm_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // rate [31:0], entries_left [38:32], zero [39]
   output logic [swrm_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [swrm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [swrm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   swrm_pkg::swrm_cmd_type    cmd;
   swrm_pkg::swrm_status_type status;

   swrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   swrm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // only one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in work");

   a_entries_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[38:32] <= swrm_pkg::CNT_W'(swrm_pkg::RING_DEPTH)))
      else $error("entries left beyond ring depth");

   a_empty_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[38:32] == '0)) |-> (rsp_tdata[31:0] == '0))
      else $error("empty channel reports a nonzero rate");

endmodule

`default_nettype wire
